/* sv/aar_pkg.sv */
// Package for the axis-angle rotation matrix block: transaction types,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
package aar_pkg;

  // Input transaction: unnormalised axis and angle (Q3.13)
  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_t;

  // Output transaction: row-major matrix in Q2.14 plus zero-axis flag
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_axis;
  } out_t;

  // Control that travels beside the normaliser pipeline
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  // CORDIC
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;  // x / y width
  localparam int ZW           = 36;  // angle accumulator width
  localparam logic signed [ZW-1:0] Q30_PI  = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HPI = 36'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  // Normaliser
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 30;
  localparam int UW        = 31;     // unit component, Q28 signed

  // Pipeline depths, counted from the input register
  localparam int LAT_CORDIC = CORDIC_STEPS + 2;
  localparam int LAT_UNIT   = SQ_STEPS + DIV_STEPS + 3;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // round(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] a;
    case (i)
      0:       a = 30'd843314857;
      1:       a = 30'd497837829;
      2:       a = 30'd263043837;
      3:       a = 30'd133525159;
      4:       a = 30'd67021687;
      5:       a = 30'd33543516;
      6:       a = 30'd16775851;
      7:       a = 30'd8388437;
      8:       a = 30'd4194283;
      9:       a = 30'd2097149;
      default: a = 30'(32'd1 << (30 - i));
    endcase
    return a;
  endfunction

endpackage

/* sv/aar_cordic.sv */
// Pipelined rotation-mode CORDIC giving cos and sin in Q30.
// Depends on aar_pkg.
module aar_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [15:0]                angle_i,
  output logic signed [aar_pkg::CW-1:0]     cos_o,
  output logic signed [aar_pkg::CW-1:0]     sin_o
);

  logic signed [aar_pkg::CW-1:0] x_q [0:aar_pkg::CORDIC_STEPS];
  logic signed [aar_pkg::CW-1:0] y_q [0:aar_pkg::CORDIC_STEPS];
  logic signed [aar_pkg::ZW-1:0] z_q [0:aar_pkg::CORDIC_STEPS];
  logic                          neg_q [0:aar_pkg::CORDIC_STEPS];

  logic signed [aar_pkg::ZW-1:0] z_in;

  assign z_in = aar_pkg::ZW'($signed({angle_i, 17'b0}));

  // Fold the angle into +/- pi/2, remember to negate the results
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= aar_pkg::CORDIC_K;
      y_q[0] <= '0;
      if (z_in > aar_pkg::Q30_HPI) begin
        z_q[0]   <= z_in - aar_pkg::Q30_PI;
        neg_q[0] <= 1'b1;
      end else if (z_in < -aar_pkg::Q30_HPI) begin
        z_q[0]   <= z_in + aar_pkg::Q30_PI;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= z_in;
        neg_q[0] <= 1'b0;
      end
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < aar_pkg::CORDIC_STEPS; i++) begin : g_iter
    logic signed [aar_pkg::CW-1:0] dx;
    logic signed [aar_pkg::CW-1:0] dy;
    logic signed [aar_pkg::ZW-1:0] a;

    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    assign a  = aar_pkg::ZW'(aar_pkg::atan_q30(i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][aar_pkg::ZW-1]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - a;
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + a;
        end
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= neg_q[aar_pkg::CORDIC_STEPS] ? -x_q[aar_pkg::CORDIC_STEPS]
                                            :  x_q[aar_pkg::CORDIC_STEPS];
      sin_o <= neg_q[aar_pkg::CORDIC_STEPS] ? -y_q[aar_pkg::CORDIC_STEPS]
                                            :  y_q[aar_pkg::CORDIC_STEPS];
    end
  end

endmodule

/* sv/aar_unit.sv */
// Axis normaliser: sum of squares, pipelined bit-pair square root and three
// pipelined restoring dividers giving the unit axis in Q28. Depends on aar_pkg.
module aar_unit (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [15:0]             axis_x_i,
  input  logic signed [15:0]             axis_y_i,
  input  logic signed [15:0]             axis_z_i,
  output logic signed [aar_pkg::UW-1:0]  u_o [3]
);

  localparam int SQ  = aar_pkg::SQ_STEPS;
  localparam int DV  = aar_pkg::DIV_STEPS;

  // Square root stages
  logic [31:0] src_q  [0:SQ];
  logic [33:0] rem_q  [0:SQ];
  logic [31:0] root_q [0:SQ];
  logic [15:0] mag_q  [0:SQ][3];
  logic        sgn_q  [0:SQ][3];

  // Divider stages
  logic [33:0] dr_q  [0:DV][3];
  logic [29:0] dq_q  [0:DV][3];
  logic [29:0] dl_q  [0:DV][3];
  logic [31:0] dd_q  [0:DV];
  logic        dsg_q [0:DV][3];

  logic signed [15:0] v [3];
  logic signed [33:0] sumsq;

  assign v[0] = axis_x_i;
  assign v[1] = axis_y_i;
  assign v[2] = axis_z_i;
  // Squares formed at 32 bits so each product is exact
  assign sumsq = 34'(32'(axis_x_i) * 32'(axis_x_i)) + 34'(32'(axis_y_i) * 32'(axis_y_i))
               + 34'(32'(axis_z_i) * 32'(axis_z_i));

  // Sum of squares and component magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      src_q[0]  <= sumsq[31:0];
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      for (int n = 0; n < 3; n++) begin
        mag_q[0][n] <= v[n][15] ? 16'(-v[n]) : 16'(v[n]);
        sgn_q[0][n] <= v[n][15];
      end
    end
  end

  // One root bit per stage; radicand is S * 2^32
  for (genvar k = 0; k < SQ; k++) begin : g_sq
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;

    assign r2    = {rem_q[k], src_q[k][31:30]};
    assign trial = {2'b00, root_q[k], 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? 34'(r2 - trial) : r2[33:0];
        root_q[k+1] <= {root_q[k][30:0], ge};
        src_q[k+1]  <= {src_q[k][29:0], 2'b00};
        for (int n = 0; n < 3; n++) begin
          mag_q[k+1][n] <= mag_q[k][n];
          sgn_q[k+1][n] <= sgn_q[k][n];
        end
      end
    end
  end

  // Divider set-up: dividend is |v| * 2^44 + R/2, top part pre-loaded
  logic [30:0] half_r;
  assign half_r = root_q[SQ][31:1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q[0] <= root_q[SQ];
      for (int n = 0; n < 3; n++) begin
        dr_q[0][n]  <= 34'({mag_q[SQ][n], 14'b0}) + 34'(half_r[30]);
        dl_q[0][n]  <= half_r[29:0];
        dq_q[0][n]  <= '0;
        dsg_q[0][n] <= sgn_q[SQ][n];
      end
    end
  end

  // One quotient bit per stage, three components side by side
  for (genvar j = 0; j < DV; j++) begin : g_div
    for (genvar n = 0; n < 3; n++) begin : g_comp
      logic [33:0] r2;
      logic        ge;

      assign r2 = {dr_q[j][n][32:0], dl_q[j][n][29]};
      assign ge = (r2 >= {2'b00, dd_q[j]});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dr_q[j+1][n]  <= ge ? r2 - {2'b00, dd_q[j]} : r2;
          dq_q[j+1][n]  <= {dq_q[j][n][28:0], ge};
          dl_q[j+1][n]  <= {dl_q[j][n][28:0], 1'b0};
          dsg_q[j+1][n] <= dsg_q[j][n];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dd_q[j+1] <= dd_q[j];
      end
    end
  end

  // Restore the sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < 3; n++) begin
        u_o[n] <= dsg_q[DV][n] ? -$signed({1'b0, dq_q[DV][n]})
                               :  $signed({1'b0, dq_q[DV][n]});
      end
    end
  end

endmodule

/* sv/axis_angle_rotation_matrix.sv */
// Axis-angle to 3x3 rotation matrix (Rodrigues form). Takes one transaction
// per clock unless stalled and returns the matching matrix; its depth is set
// by the normaliser (32-stage square root followed by 30-stage dividers),
// with the CORDIC running beside it and three product/sum stages after. The
// whole pipeline advances together whenever the output register is empty or
// being taken, so back-pressure stalls it without losing transactions. A
// zero-length axis gives the identity with zero_axis set.
// Depends on aar_pkg, aar_cordic and aar_unit.
module axis_angle_rotation_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aar_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output aar_pkg::out_t  out_data_o
);

  localparam int LU = aar_pkg::LAT_UNIT;
  localparam int LD = aar_pkg::LAT_UNIT - aar_pkg::LAT_CORDIC;
  localparam int CW = aar_pkg::CW;
  localparam int UW = aar_pkg::UW;

  logic adv;

  // Input register
  logic          v0_q;
  aar_pkg::in_t  in_q;

  // Side pipelines
  aar_pkg::ctl_t           ctl_q [0:LU-1];
  logic signed [CW-1:0]    cd_q  [0:LD-1];
  logic signed [CW-1:0]    sd_q  [0:LD-1];
  logic signed [CW-1:0]    cos_w;
  logic signed [CW-1:0]    sin_w;
  logic signed [UW-1:0]    u_w [3];

  // Product stages
  aar_pkg::ctl_t           p1_ctl_q;
  logic signed [61:0]      pp_q [6];   // 00 11 22 01 02 12
  logic signed [64:0]      us_q [3];
  logic signed [33:0]      t_q;
  logic signed [CW-1:0]    c1_q;

  aar_pkg::ctl_t           p2_ctl_q;
  logic signed [63:0]      ut_q [6];
  logic signed [63:0]      us4_q [3];
  logic signed [63:0]      cs_q;

  logic                    p3_valid_q;
  aar_pkg::out_t           out_q;

  assign adv         = !p3_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = p3_valid_q;
  assign out_data_o  = out_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_data_i;
    end
  end

  aar_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (in_q.angle),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  aar_unit u_unit (
    .clk_i    (clk_i),
    .en_i     (adv),
    .axis_x_i (in_q.axis_x),
    .axis_y_i (in_q.axis_y),
    .axis_z_i (in_q.axis_z),
    .u_o      (u_w)
  );

  // Valid and zero flag alongside the normaliser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LU; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (adv) begin
      ctl_q[0].valid <= v0_q;
      ctl_q[0].zero  <= (in_q.axis_x == '0) && (in_q.axis_y == '0)
                     && (in_q.axis_z == '0);
      for (int k = 1; k < LU; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // Hold cos/sin until the unit axis is ready
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cd_q[0] <= cos_w;
      sd_q[0] <= sin_w;
      for (int k = 1; k < LD; k++) begin
        cd_q[k] <= cd_q[k-1];
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // P1: axis products and axis times sine
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q[0] <= u_w[0] * u_w[0];
      pp_q[1] <= u_w[1] * u_w[1];
      pp_q[2] <= u_w[2] * u_w[2];
      pp_q[3] <= u_w[0] * u_w[1];
      pp_q[4] <= u_w[0] * u_w[2];
      pp_q[5] <= u_w[1] * u_w[2];
      for (int n = 0; n < 3; n++) begin
        us_q[n] <= u_w[n] * sd_q[LD-1];
      end
      t_q  <= 34'sd1073741824 - cd_q[LD-1];
      c1_q <= cd_q[LD-1];
    end
  end

  // P2: round the products to Q30 and scale by one minus cos
  for (genvar p = 0; p < 6; p++) begin : g_ut
    logic signed [61:0] pr;
    logic signed [31:0] uu;
    logic signed [65:0] full;

    assign pr   = pp_q[p] + 62'sd33554432;
    assign uu   = $signed(pr[57:26]);   // at most one in Q30
    assign full = uu * t_q;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ut_q[p] <= $signed(full[63:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int n = 0; n < 3; n++) begin
        us4_q[n] <= $signed({us_q[n][61:0], 2'b00});
      end
      cs_q <= $signed({c1_q, 30'b0});
    end
  end

  // Q60 to Q2.14, round half up, clamp to +/- one
  function automatic logic signed [15:0] to_q14(input logic signed [63:0] v);
    logic signed [63:0] r;
    logic signed [17:0] q;
    r = v + 64'sd35184372088832;
    q = $signed(r[63:46]);
    if (q > 18'sd16384) begin
      return aar_pkg::ONE_Q14;
    end else if (q < -18'sd16384) begin
      return -aar_pkg::ONE_Q14;
    end
    return q[15:0];
  endfunction

  // P3: sum and output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (p2_ctl_q.zero) begin
        out_q.m00 <= aar_pkg::ONE_Q14;
        out_q.m01 <= '0;
        out_q.m02 <= '0;
        out_q.m10 <= '0;
        out_q.m11 <= aar_pkg::ONE_Q14;
        out_q.m12 <= '0;
        out_q.m20 <= '0;
        out_q.m21 <= '0;
        out_q.m22 <= aar_pkg::ONE_Q14;
      end else begin
        out_q.m00 <= to_q14(cs_q + ut_q[0]);
        out_q.m11 <= to_q14(cs_q + ut_q[1]);
        out_q.m22 <= to_q14(cs_q + ut_q[2]);
        out_q.m01 <= to_q14(ut_q[3] - us4_q[2]);
        out_q.m10 <= to_q14(ut_q[3] + us4_q[2]);
        out_q.m02 <= to_q14(ut_q[4] + us4_q[1]);
        out_q.m20 <= to_q14(ut_q[4] - us4_q[1]);
        out_q.m12 <= to_q14(ut_q[5] - us4_q[0]);
        out_q.m21 <= to_q14(ut_q[5] + us4_q[0]);
      end
      out_q.zero_axis <= p2_ctl_q.zero;
    end
  end

  // Control through the product stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_ctl_q   <= '0;
      p2_ctl_q   <= '0;
      p3_valid_q <= 1'b0;
    end else if (adv) begin
      p1_ctl_q   <= ctl_q[LU-1];
      p2_ctl_q   <= p1_ctl_q;
      p3_valid_q <= p2_ctl_q.valid;
    end
  end

endmodule

/* dv/rotation_checker.sv */
`timescale 1ns / 100ps
// Checker for the axis-angle rotation matrix block: watches both channels,
// computes the expected matrix for each input transaction and compares.
// Depends on aar_pkg for the transaction types.
module rotation_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  aar_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  aar_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            matrices_seen_o
);

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint HPI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;

  aar_pkg::out_t expected_matrices[$];
  int   fail_count = 0;
  int   matrices_seen = 0;
  int   pending = 0;

  assign fail_count_o    = fail_count;
  assign pending_o       = pending;
  assign matrices_seen_o = matrices_seen;

  function automatic longint floor_div_pow2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    return longint'(1) << (30 - i);
  endfunction

  function automatic longint isqrt(longint unsigned num);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > num) bit_v >>= 2;
    while (bit_v != 0) begin
      if (num >= res + bit_v) begin
        num -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [15:0] clamp_q14(longint v);
    longint r;
    r = (v + (longint'(1) <<< 45)) >>> 46;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // Rodrigues matrix for one transaction
  function automatic aar_pkg::out_t rotation_of(aar_pkg::in_t item);
    aar_pkg::out_t res;
    longint ax[3], u[3], uu[3][3], z, x, y, dx, dy, c, s, t, sq, mag;
    longint unsigned r;
    bit flip;
    ax[0] = item.axis_x; ax[1] = item.axis_y; ax[2] = item.axis_z;
    res = '0;
    if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) begin
      res.m00 = aar_pkg::ONE_Q14; res.m11 = aar_pkg::ONE_Q14; res.m22 = aar_pkg::ONE_Q14;
      res.zero_axis = 1'b1;
      return res;
    end
    // sin / cos by rotation-mode CORDIC, range folded by pi
    z = longint'(item.angle) * 131072;
    flip = 0;
    if (z > HPI_Q30) begin z -= PI_Q30; flip = 1; end
    else if (z < -HPI_Q30) begin z += PI_Q30; flip = 1; end
    x = GAIN_Q30; y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = floor_div_pow2(y, i);
      dy = floor_div_pow2(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = (longint'(1) << 30) - c;
    // unit axis in Q28
    sq = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
    r = longint'(isqrt(longint'(sq) << 32));
    for (int i = 0; i < 3; i++) begin
      mag = ax[i] < 0 ? -ax[i] : ax[i];
      u[i] = longint'(((longint'(mag) << 44) + (r >> 1)) / r);
      if (ax[i] < 0) u[i] = -u[i];
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        uu[i][j] = ((u[i] * u[j] + (longint'(1) <<< 25)) >>> 26) * t;
    res.m00 = clamp_q14(c * (longint'(1) << 30) + uu[0][0]);
    res.m11 = clamp_q14(c * (longint'(1) << 30) + uu[1][1]);
    res.m22 = clamp_q14(c * (longint'(1) << 30) + uu[2][2]);
    res.m01 = clamp_q14(uu[0][1] - 4 * (u[2] * s));
    res.m02 = clamp_q14(uu[0][2] + 4 * (u[1] * s));
    res.m10 = clamp_q14(uu[1][0] + 4 * (u[2] * s));
    res.m12 = clamp_q14(uu[1][2] - 4 * (u[0] * s));
    res.m20 = clamp_q14(uu[2][0] - 4 * (u[1] * s));
    res.m21 = clamp_q14(uu[2][1] + 4 * (u[0] * s));
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic compare_matrix(aar_pkg::out_t got, aar_pkg::out_t want);
    if (got.m00 != want.m00) report_mismatch("m00", got.m00, want.m00);
    if (got.m01 != want.m01) report_mismatch("m01", got.m01, want.m01);
    if (got.m02 != want.m02) report_mismatch("m02", got.m02, want.m02);
    if (got.m10 != want.m10) report_mismatch("m10", got.m10, want.m10);
    if (got.m11 != want.m11) report_mismatch("m11", got.m11, want.m11);
    if (got.m12 != want.m12) report_mismatch("m12", got.m12, want.m12);
    if (got.m20 != want.m20) report_mismatch("m20", got.m20, want.m20);
    if (got.m21 != want.m21) report_mismatch("m21", got.m21, want.m21);
    if (got.m22 != want.m22) report_mismatch("m22", got.m22, want.m22);
    if (got.zero_axis != want.zero_axis)
      report_mismatch("zero_axis", got.zero_axis, want.zero_axis);
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_matrices.push_back(rotation_of(in_data_i));
      if (out_valid_i && out_ready_i) begin
        matrices_seen++;
        if (expected_matrices.size() == 0)
          report_mismatch("unexpected transaction", 1, 0);
        else
          compare_matrix(out_data_i, expected_matrices.pop_front());
      end
      pending = expected_matrices.size();
    end
  end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Top of the rotation matrix testbench: clock, reset, stimulus and verdict.
// Depends on aar_pkg, axis_angle_rotation_matrix and rotation_checker.
module testbench;

  localparam int LATENCY     = 68;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1030;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  aar_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aar_pkg::out_t out_data;
  int   fail_count, pending, matrices_seen;
  int   cycles = 0;
  bit   quiet_phase = 0;   // no idling on either side
  bit   hold_sink = 0;     // long receiver hold-off
  int   sent = 0;

  axis_angle_rotation_matrix dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  rotation_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .matrices_seen_o(matrices_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    repeat (9) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_sink) out_ready <= 1'b0;
      else out_ready <= quiet_phase || ($urandom_range(99) >= 21);
    end
  end

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(8)) - 4);
      3: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(51472)) - 25736);
      3: return 16'($urandom);
      default: return 16'(signed'($urandom_range(51472)) - 25736);
    endcase
  endfunction

  // Offer one transaction, after random idle gaps if allowed, and hold it until accepted
  task automatic send_axis_angle(logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z, logic signed [15:0] a,
                                 bit allow_gap);
    if (allow_gap && !quiet_phase)
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_data  <= '{axis_x: x, axis_y: y, axis_z: z, angle: a};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, zero axis, angle folding, beyond-pi angles
    send_axis_angle(0, 0, 0, 16'sd1000, 1);
    send_axis_angle(0, 0, 0, 16'sh8000, 1);
    send_axis_angle(1, 0, 0, 16'sd12868, 1);
    send_axis_angle(0, 1, 0, -16'sd12868, 1);
    send_axis_angle(0, 0, 1, 16'sd25736, 1);
    send_axis_angle(0, 0, -1, -16'sd25736, 1);
    send_axis_angle(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1);
    send_axis_angle(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1);
    send_axis_angle(16'sh8000, 0, 0, 0, 1);
    send_axis_angle(16'sh7FFF, 1, -1, 16'sd1, 1);
    send_axis_angle(3, 4, 0, 16'sd12869, 1);
    send_axis_angle(-3, 4, 12, -16'sd12869, 1);
    send_axis_angle(1, 1, 1, 16'sd26000, 1);
    send_axis_angle(-1, -1, -1, -16'sd26000, 1);
    send_axis_angle(16'sh5555, 16'shAAAA, 16'sh00FF, 16'sh5555, 1);
    send_axis_angle(16'shAAAA, 16'sh5555, 16'shFF00, 16'shAAAA, 1);
    send_axis_angle(0, 0, 16'sh7FFF, 16'sd6434, 1);
    send_axis_angle(0, 16'sh8000, 0, -16'sd6434, 1);
    send_axis_angle(1, 2, 3, 0, 1);
    send_axis_angle(0, 0, 0, 0, 1);

    // Pause until everything has come back
    drain();

    // Long receiver hold-off so the pipeline fills and stalls the input
    fork
      begin
        hold_sink = 1;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end
      repeat (150) send_axis_angle(pick_axis(), pick_axis(), pick_axis(), pick_angle(), 0);
    join

    // Random part, with a stretch without idling in the middle
    for (int n = 0; n < RANDOM_ITEMS - 150; n++) begin
      quiet_phase = (n >= 300 && n < 500);
      send_axis_angle(pick_axis(), pick_axis(), pick_axis(), pick_angle(), 1);
    end
    quiet_phase = 0;
    drain();
    repeat (LATENCY + 10) @(negedge clk);

    $display("sent %0d axis-angle transactions, checked %0d matrices", sent, matrices_seen);
    $display("covered zero axis, extreme axes, folded and beyond-pi angles, back-pressure");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
